// File: hdl/grou_pkg.sv
// Shared constants, types and helpers for the ratio-of-uniforms normal generator.
`default_nettype none

package grou_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int Q_BITS      = 30;
   localparam int DIV_BITS    = 34;

   localparam int QUAD_LAT = 6;
   localparam int LOG_LAT  = 34;
   localparam int DIV_LAT  = 37;

   localparam logic [63:0] Q_ONE = 64'd1 << Q_BITS;

   localparam logic [30:0] K_SCALE = 31'((64'd17156 * Q_ONE + 64'd5000) / 64'd10000);
   localparam logic [29:0] K_HALF  = 30'(Q_ONE / 64'd2);
   localparam logic [29:0] K_UOFF  = 30'((64'd449871 * Q_ONE + 64'd500000) / 64'd1000000);
   localparam logic [29:0] K_YOFF  = 30'((64'd386595 * Q_ONE + 64'd500000) / 64'd1000000);
   localparam logic [29:0] K_YY    = 30'((64'd19600 * Q_ONE + 64'd50000) / 64'd100000);
   localparam logic [29:0] K_XY    = 30'((64'd25472 * Q_ONE + 64'd50000) / 64'd100000);
   localparam logic [29:0] K_INNER = 30'((64'd27597 * Q_ONE + 64'd50000) / 64'd100000);
   localparam logic [29:0] K_OUTER = 30'((64'd27846 * Q_ONE + 64'd50000) / 64'd100000);
   localparam logic [29:0] K_LN2   =
      30'((64'd6931471806 * Q_ONE + 64'd5000000000) / 64'd10000000000);

   localparam logic [DIV_BITS-1:0] RATIO_CLAMP = DIV_BITS'(64'd1 << 33);

   localparam logic [31:0] STD_RESET = 32'd65536;

   typedef enum logic [0:0] {
      CSR_MEAN = 1'b0,
      CSR_STD  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [29:0] u;
      logic [29:0] vm;
      logic [29:0] lhs;
      logic        inner;
      logic        outer;
      logic        vneg;
   } quad_out_type;

   function automatic logic [29:0] to_q30(input logic [31:0] raw);
      logic [63:0] s;
      s = 64'(raw) & ((64'd1 << SAMPLE_BITS) - 64'd1);
      if (SAMPLE_BITS >= Q_BITS) begin
         s = s >> (SAMPLE_BITS - Q_BITS);
      end else begin
         s = s << (Q_BITS - SAMPLE_BITS);
      end
      return s[29:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/gaussian_ratio_of_uniforms.sv
// Top level of the ratio-of-uniforms normal deviate generator.
//
//   port group   direction  word
//   req_*        in         u_sample, v_sample pair
//   rsp_*        out        normal_deviate, only for accepted pairs
//   csr_*        in         mean_value, std_deviation writes
//
// One pair enters per cycle unless the output word stalls; an accepted pair leaves
// through the 34-step divider that follows the 6-stage quadratic-form pipe.
// The 30 squaring stages of the log run alongside and finish first.
// A stalled output word freezes the whole pipe; req_tready follows that freeze.
// Reset is synchronous; it clears valid bits and loads the register defaults.
`default_nettype none

module gaussian_ratio_of_uniforms (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // u_sample[31:0], v_sample[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // normal_deviate[31:0]
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import grou_pkg::*;

   localparam int TOT     = QUAD_LAT + DIV_LAT;
   localparam int ACC_DLY = LOG_LAT - QUAD_LAT;
   localparam int OUT_DLY = TOT - LOG_LAT;

   typedef struct packed {
      logic [29:0] lhs;
      logic        inner;
      logic        outer;
      logic        vneg;
   } chk_type;

   typedef struct packed {
      logic acc;
      logic vneg;
   } sel_type;

   logic        en;
   logic [29:0] u_in, v_in, u0_ff, v0_ff;
   logic        vld_ff [0:TOT];

   logic [31:0] mean_ff;
   logic [30:0] std_ff;

   quad_out_type        quad_res;
   logic [39:0]         rhs;
   logic [DIV_BITS-1:0] mag;

   chk_type dly_a_ff [1:ACC_DLY];
   sel_type dly_b_ff [1:OUT_DLY];
   sel_type sel_in;

   logic signed [35:0] sum;
   logic [31:0]        rsp_data_in, rsp_data_ff;
   logic               rsp_valid_in, rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign u_in       = to_q30(req_tdata[31:0]);
   assign v_in       = to_q30(req_tdata[63:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         std_ff  <= 31'(STD_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEAN: begin
               mean_ff <= csr_wdata;
            end
            CSR_STD: begin
               std_ff <= csr_wdata[30:0];
            end
            default: begin
               mean_ff <= mean_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= TOT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid && (u_in != '0) && (v_in != '0);
         for (int k = 1; k <= TOT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u0_ff <= u_in;
         v0_ff <= v_in;
      end
   end

   grou_quad u_quad (
      .clock  (clock),
      .en     (en),
      .u      (u0_ff),
      .vf     (v0_ff),
      .result (quad_res)
   );

   grou_log u_log (
      .clock (clock),
      .en    (en),
      .u     (u0_ff),
      .rhs   (rhs)
   );

   grou_div u_div (
      .clock   (clock),
      .en      (en),
      .std_dev (std_ff),
      .vm      (quad_res.vm),
      .u       (quad_res.u),
      .mag     (mag)
   );

   always_comb begin
      sel_in.vneg = dly_a_ff[ACC_DLY].vneg;
      sel_in.acc  = dly_a_ff[ACC_DLY].inner ||
                    (!dly_a_ff[ACC_DLY].outer && (40'(dly_a_ff[ACC_DLY].lhs) <= rhs));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_a_ff[1] <= '{lhs: quad_res.lhs, inner: quad_res.inner,
                          outer: quad_res.outer, vneg: quad_res.vneg};
         for (int k = 2; k <= ACC_DLY; k++) begin
            dly_a_ff[k] <= dly_a_ff[k-1];
         end
         dly_b_ff[1] <= sel_in;
         for (int k = 2; k <= OUT_DLY; k++) begin
            dly_b_ff[k] <= dly_b_ff[k-1];
         end
      end
   end

   always_comb begin
      sum = $signed({{4{mean_ff[31]}}, mean_ff});
      if (dly_b_ff[OUT_DLY].vneg) begin
         sum = sum - $signed(36'(mag));
      end else begin
         sum = sum + $signed(36'(mag));
      end
      if (sum > $signed(36'h07FFFFFFF)) begin
         rsp_data_in = 32'h7FFFFFFF;
      end else if (sum < -$signed(36'h080000000)) begin
         rsp_data_in = 32'h80000000;
      end else begin
         rsp_data_in = sum[31:0];
      end
      rsp_valid_in = vld_ff[TOT] && dly_b_ff[OUT_DLY].acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_emit: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[TOT] && dly_b_ff[OUT_DLY].acc) |=> rsp_tvalid)
      else $error("accepted pair did not reach the output register");

   a_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(vld_ff[TOT]))
      else $error("output word without a valid pipeline entry");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (u_in == '0 || v_in == '0)) |=> !vld_ff[0])
      else $error("zero sample entered the pipeline");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> (vld_ff[TOT] == $past(vld_ff[TOT])))
      else $error("pipeline advanced during a stall");

endmodule

`default_nettype wire

// File: hdl/grou_quad.sv
// Pipelined evaluation of the scaled v sample and the quadratic acceptance form.
`default_nettype none

module grou_quad (
   input  logic                  clock,
   input  logic                  en,
   input  logic [29:0]           u,
   input  logic [29:0]           vf,
   output grou_pkg::quad_out_type result
);
   import grou_pkg::*;

   logic        vneg1_in, vneg1_ff, xneg1_in, xneg1_ff;
   logic [29:0] vmag1_in, vmag1_ff, ax1_in, ax1_ff, u1_ff;

   logic [60:0] vprod2;
   logic [59:0] xprod2, bprod2;
   logic [29:0] vm2_in, vm2_ff, x2_2_in, x2_2_ff, b2_in, b2_ff, u2_ff;
   logic        xneg2_ff, vneg2_ff;

   logic [30:0] y3_in, y3_ff;
   logic [60:0] aprod3;
   logic [59:0] lprod3;
   logic [29:0] a3_in, a3_ff, lhs3_in, lhs3_ff, x2_3_ff, b3_ff, vm3_ff, u3_ff;
   logic        xneg3_ff, vneg3_ff;

   logic        tpos4_in, tpos4_ff, vneg4_ff;
   logic [30:0] tm4_in, tm4_ff, y4_ff;
   logic [29:0] x2_4_ff, lhs4_ff, vm4_ff, u4_ff;

   logic [61:0] yprod5;
   logic [31:0] yt5_in, yt5_ff;
   logic        tpos5_ff, vneg5_ff;
   logic [29:0] x2_5_ff, lhs5_ff, vm5_ff, u5_ff;

   logic [33:0]  pos6;
   quad_out_type result_in, result_ff;

   always_comb begin
      vneg1_in = vf < K_HALF;
      vmag1_in = vneg1_in ? K_HALF - vf : vf - K_HALF;
      xneg1_in = u < K_UOFF;
      ax1_in   = xneg1_in ? K_UOFF - u : u - K_UOFF;
   end

   always_comb begin
      vprod2  = 61'(vmag1_ff) * 61'(K_SCALE);
      vm2_in  = vprod2[59:30];
      xprod2  = 60'(ax1_ff) * 60'(ax1_ff);
      x2_2_in = xprod2[59:30];
      bprod2  = 60'(K_XY) * 60'(ax1_ff);
      b2_in   = bprod2[59:30];
   end

   always_comb begin
      y3_in   = 31'(vm2_ff) + 31'(K_YOFF);
      aprod3  = 61'(K_YY) * 61'(y3_in);
      a3_in   = aprod3[59:30];
      lprod3  = 60'(vm2_ff) * 60'(vm2_ff);
      lhs3_in = lprod3[59:30];
   end

   always_comb begin
      if (xneg3_ff) begin
         tpos4_in = 1'b1;
         tm4_in   = 31'(a3_ff) + 31'(b3_ff);
      end else if (a3_ff >= b3_ff) begin
         tpos4_in = 1'b1;
         tm4_in   = 31'(a3_ff - b3_ff);
      end else begin
         tpos4_in = 1'b0;
         tm4_in   = 31'(b3_ff - a3_ff);
      end
   end

   always_comb begin
      yprod5 = 62'(y4_ff) * 62'(tm4_ff);
      yt5_in = yprod5[61:30];
   end

   always_comb begin
      pos6            = 34'(x2_5_ff) + 34'(yt5_ff);
      result_in.u     = u5_ff;
      result_in.vm    = vm5_ff;
      result_in.lhs   = lhs5_ff;
      result_in.vneg  = vneg5_ff;
      if (tpos5_ff) begin
         result_in.inner = pos6 < 34'(K_INNER);
         result_in.outer = pos6 > 34'(K_OUTER);
      end else begin
         result_in.inner = 34'(x2_5_ff) < 34'(yt5_ff) + 34'(K_INNER);
         result_in.outer = 34'(x2_5_ff) > 34'(yt5_ff) + 34'(K_OUTER);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vneg1_ff  <= vneg1_in;
         vmag1_ff  <= vmag1_in;
         xneg1_ff  <= xneg1_in;
         ax1_ff    <= ax1_in;
         u1_ff     <= u;

         vm2_ff    <= vm2_in;
         x2_2_ff   <= x2_2_in;
         b2_ff     <= b2_in;
         xneg2_ff  <= xneg1_ff;
         vneg2_ff  <= vneg1_ff;
         u2_ff     <= u1_ff;

         y3_ff     <= y3_in;
         a3_ff     <= a3_in;
         lhs3_ff   <= lhs3_in;
         x2_3_ff   <= x2_2_ff;
         b3_ff     <= b2_ff;
         vm3_ff    <= vm2_ff;
         xneg3_ff  <= xneg2_ff;
         vneg3_ff  <= vneg2_ff;
         u3_ff     <= u2_ff;

         tpos4_ff  <= tpos4_in;
         tm4_ff    <= tm4_in;
         y4_ff     <= y3_ff;
         x2_4_ff   <= x2_3_ff;
         lhs4_ff   <= lhs3_ff;
         vm4_ff    <= vm3_ff;
         vneg4_ff  <= vneg3_ff;
         u4_ff     <= u3_ff;

         yt5_ff    <= yt5_in;
         tpos5_ff  <= tpos4_ff;
         x2_5_ff   <= x2_4_ff;
         lhs5_ff   <= lhs4_ff;
         vm5_ff    <= vm4_ff;
         vneg5_ff  <= vneg4_ff;
         u5_ff     <= u4_ff;

         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// File: hdl/grou_log.sv
// Pipelined -4*u^2*ln(u) bound using a squaring log2 chain.
`default_nettype none

module grou_log (
   input  logic        clock,
   input  logic        en,
   input  logic [29:0] u,
   output logic [39:0] rhs
);
   import grou_pkg::*;

   localparam int STEPS = Q_BITS;

   logic [4:0]  lead_in, sh_in;
   logic [30:0] m0_in;
   logic [59:0] uprod;

   logic [30:0] m_ff    [0:STEPS];
   logic [29:0] frac_ff [0:STEPS];
   logic [4:0]  sh_ff   [0:STEPS];
   logic [29:0] usq_ff  [0:STEPS];

   logic [34:0] nl2_in, nl2_ff;
   logic [29:0] usq32_ff, usq33_ff;
   logic [34:0] ipr;
   logic [59:0] fpr;
   logic [35:0] nl_in, nl_ff;
   logic [39:0] hi, rhs_in, rhs_ff;
   logic [59:0] lo;

   always_comb begin
      lead_in = 5'd0;
      for (int i = 0; i < Q_BITS; i++) begin
         if (u[i]) begin
            lead_in = 5'(i);
         end
      end
      sh_in = 5'(Q_BITS) - lead_in;
      m0_in = 31'({1'b0, u} << sh_in);
      uprod = 60'(u) * 60'(u);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]    <= m0_in;
         frac_ff[0] <= '0;
         sh_ff[0]   <= sh_in;
         usq_ff[0]  <= uprod[59:30];
      end
   end

   for (genvar j = 1; j <= STEPS; j++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      logic [30:0] m_in;
      logic [29:0] frac_in;

      always_comb begin
         sq      = 62'(m_ff[j-1]) * 62'(m_ff[j-1]);
         t       = sq[61:30];
         m_in    = t[31] ? t[31:1] : t[30:0];
         frac_in = frac_ff[j-1] | (t[31] ? (30'd1 << (Q_BITS - j)) : 30'd0);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[j]    <= m_in;
            frac_ff[j] <= frac_in;
            sh_ff[j]   <= sh_ff[j-1];
            usq_ff[j]  <= usq_ff[j-1];
         end
      end
   end

   always_comb begin
      nl2_in = {sh_ff[STEPS], 30'd0} - 35'(frac_ff[STEPS]);
      ipr    = 35'(nl2_ff[34:30]) * 35'(K_LN2);
      fpr    = 60'(nl2_ff[29:0]) * 60'(K_LN2);
      nl_in  = 36'(ipr) + 36'(fpr[59:30]);
      hi     = 40'(usq33_ff) * 40'(nl_ff[35:30]);
      lo     = 60'(usq33_ff) * 60'(nl_ff[29:0]);
      rhs_in = (hi + 40'(lo[59:30])) << 2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nl2_ff   <= nl2_in;
         usq32_ff <= usq_ff[STEPS];
         nl_ff    <= nl_in;
         usq33_ff <= usq32_ff;
         rhs_ff   <= rhs_in;
      end
   end

   assign rhs = rhs_ff;

endmodule

`default_nettype wire

// File: hdl/grou_div.sv
// Pipelined restoring divider for the clamped ratio stddev*v/u.
`default_nettype none

module grou_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [30:0]                   std_dev,
   input  logic [29:0]                   vm,
   input  logic [29:0]                   u,
   output logic [grou_pkg::DIV_BITS-1:0] mag
);
   import grou_pkg::*;

   logic [60:0] n_in, n1_ff;
   logic [29:0] u1_ff;

   logic [29:0]         rem_ff [0:DIV_BITS];
   logic [DIV_BITS-1:0] low_ff [0:DIV_BITS];
   logic [DIV_BITS-1:0] quo_ff [0:DIV_BITS];
   logic [29:0]         dv_ff  [0:DIV_BITS];
   logic                ovf_ff [0:DIV_BITS];

   logic [DIV_BITS-1:0] mag_in, mag_ff;

   assign n_in = 61'(std_dev) * 61'(vm);

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff     <= n_in;
         u1_ff     <= u;
         rem_ff[0] <= 30'(n1_ff[60:DIV_BITS]);
         low_ff[0] <= n1_ff[DIV_BITS-1:0];
         quo_ff[0] <= '0;
         dv_ff[0]  <= u1_ff;
         ovf_ff[0] <= 30'(n1_ff[60:DIV_BITS]) >= u1_ff;
      end
   end

   for (genvar j = 1; j <= DIV_BITS; j++) begin : g_step
      logic [30:0]         t;
      logic                ge;
      logic [29:0]         rem_in;
      logic [DIV_BITS-1:0] quo_in;

      always_comb begin
         t      = {rem_ff[j-1], low_ff[j-1][DIV_BITS-j]};
         ge     = t >= {1'b0, dv_ff[j-1]};
         rem_in = ge ? 30'(t - {1'b0, dv_ff[j-1]}) : t[29:0];
         quo_in = quo_ff[j-1] | (ge ? ({{(DIV_BITS-1){1'b0}}, 1'b1} << (DIV_BITS - j))
                                    : '0);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= low_ff[j-1];
            quo_ff[j] <= quo_in;
            dv_ff[j]  <= dv_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign mag_in = (ovf_ff[DIV_BITS] || quo_ff[DIV_BITS] > RATIO_CLAMP) ? RATIO_CLAMP
                                                                        : quo_ff[DIV_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
      end
   end

   assign mag = mag_ff;

endmodule

`default_nettype wire
